// ----- rtl/stx_etx_dle_frame_decoder_top_assert.svh -----
// Assertion macros shared by the frame decoder RTL.
// No dependencies; the files that assert include this header by name.
`ifndef STX_ETX_DLE_FRAME_DECODER_TOP_ASSERT_SVH
`define STX_ETX_DLE_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define STXD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Same-cycle implication failed in frame decoder.");
// Next-cycle implication, checked out of reset.
`define STXD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle implication failed in frame decoder.");
`else
`define STXD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STXD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/stxd_pkg.sv -----
// Types and constants for the STX/ETX/DLE frame decoder.
// Used by every module of the decoder; depends on nothing.
package stxd_pkg;

    localparam int ByteW    = 8;
    localparam int LenW     = 13;
    localparam int CntW     = 32;
    localparam int KindW    = 3;
    localparam int MaxFrame = 4096;
    localparam int ResBits  = ByteW + LenW + 2 * CntW;
    localparam int DataW    = ((ResBits + 7) / 8) * 8;

    localparam logic [ByteW-1:0] Stx = 8'h02;
    localparam logic [ByteW-1:0] Etx = 8'h03;
    localparam logic [ByteW-1:0] Dle = 8'h10;

    localparam logic [LenW-1:0] MaxLenReset = LenW'(MaxFrame);

    typedef enum logic [KindW-1:0] {
        KIND_PAYLOAD = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BAD_SUM = 3'd2,
        KIND_ABORT   = 3'd3,
        KIND_LONG    = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FRAME = 4'b0010,
        ST_ESC   = 4'b0100,
        ST_CSUM  = 4'b1000
    } t_mode;

    typedef struct packed {
        t_kind             kind;
        logic [ByteW-1:0]  payload;
        logic [LenW-1:0]   length;
        logic [CntW-1:0]   good_frames;
        logic [CntW-1:0]   err_frames;
    } t_result;

endpackage

// ----- rtl/stx_etx_dle_frame_decoder_top.sv -----
// Top level of the STX/ETX/DLE serial frame decoder.
// Depends on stxd_pkg, stxd_in_stage, stxd_core and stxd_out_stage.
//
//  Channel   Direction  Content
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         one received serial byte per transfer
//  m_axis    out        one decoder result per transfer (payload or verdict)
//  i_cfg_*   in         write of max_length, taken at once, no read-back
//
// One byte a cycle is sustained while m_axis takes every result: a byte sits
// in the input register, is decoded by shallow logic and its result lands in
// the output register, from which it is offered on m_axis.
// Reset (synchronous, active low) empties both registers, returns to the
// between-frames state, clears the checksum, length and both frame counters,
// and sets max_length to 4096.
// A stall on m_axis holds the decoder only while the output register is full
// and not taken; s_axis_tready then falls as soon as the input register holds
// a byte.
//
// Each payload byte is passed on at once. The verdict at the end of a frame
// (good, bad checksum, aborted by a new STX, or too long) tells the consumer
// whether to keep the bytes it has already seen. Bytes outside a frame give
// no result, nor do ETX and DLE inside a frame.
module stx_etx_dle_frame_decoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] rx_byte
    input  logic [stxd_pkg::ByteW-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] payload_byte, [20:8] frame_length, [52:21] good_frames,
    // [84:53] error_frames, [87:85] zero
    output logic [stxd_pkg::DataW-1:0]  m_axis_tdata,
    // [2:0] kind
    output logic [stxd_pkg::KindW-1:0]  m_axis_tuser,
    input  logic                        i_cfg_we,
    input  logic [stxd_pkg::LenW-1:0]   i_cfg_wdata
);

    logic                       in_valid;
    logic [stxd_pkg::ByteW-1:0] in_byte;
    logic                       adv;
    logic                       out_free;
    logic                       res_valid;
    stxd_pkg::t_result          res;
    stxd_pkg::t_result          out_res;

    // A held byte moves on whenever the output register can take its result.
    // Bytes that give no result follow the same rule, which keeps it simple.
    assign adv = in_valid && out_free;

    stxd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_take  (adv),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    stxd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    stxd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // Fields packed from the lowest bit up, padded with zeros to whole bytes.
    assign m_axis_tdata = stxd_pkg::DataW'({out_res.err_frames, out_res.good_frames,
                                            out_res.length, out_res.payload});
    assign m_axis_tuser = out_res.kind;

endmodule

// ----- rtl/stxd_in_stage.sv -----
// Input register of the frame decoder: holds one received byte.
// Depends on stxd_pkg.
module stxd_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [stxd_pkg::ByteW-1:0] i_byte,
    input  logic                      i_take,
    output logic                      o_valid,
    output logic [stxd_pkg::ByteW-1:0] o_byte
);

    logic                       r_valid;
    logic                       n_valid;
    logic [stxd_pkg::ByteW-1:0] r_byte;

    // The register is free when empty or when its byte leaves this cycle.
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- rtl/stxd_core.sv -----
// Framing state, checksum, length and frame counters of the decoder.
// Depends on stxd_pkg and stx_etx_dle_frame_decoder_top_assert.svh.
`include "stx_etx_dle_frame_decoder_top_assert.svh"
module stxd_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stxd_pkg::LenW-1:0]  i_cfg_wdata,
    input  logic                       i_adv,
    input  logic [stxd_pkg::ByteW-1:0] i_byte,
    output logic                       o_res_valid,
    output stxd_pkg::t_result          o_res
);

    stxd_pkg::t_mode             r_mode, n_mode;
    logic [stxd_pkg::ByteW-1:0]  r_sum, n_sum;
    logic [stxd_pkg::LenW-1:0]   r_len, n_len;
    logic [stxd_pkg::CntW-1:0]   r_good, n_good;
    logic [stxd_pkg::CntW-1:0]   r_err, n_err;
    logic [stxd_pkg::LenW-1:0]   r_max_len;
    logic [stxd_pkg::LenW-1:0]   limit;
    logic [stxd_pkg::LenW-1:0]   len_inc;
    logic                        do_payload;

    // The programmed limit is clamped to the largest frame the design supports.
    assign limit = (32'(r_max_len) > stxd_pkg::MaxFrame) ?
                   stxd_pkg::LenW'(stxd_pkg::MaxFrame) : r_max_len;
    assign len_inc = r_len + stxd_pkg::LenW'(1);

    always_comb begin
        n_mode      = r_mode;
        n_sum       = r_sum;
        n_len       = r_len;
        n_good      = r_good;
        n_err       = r_err;
        do_payload  = 1'b0;
        o_res_valid = 1'b0;
        o_res.kind  = stxd_pkg::KIND_PAYLOAD;
        o_res.payload = '0;
        o_res.length  = r_len;

        case (r_mode)
            stxd_pkg::ST_IDLE: begin
                if (i_byte == stxd_pkg::Stx) begin
                    n_mode = stxd_pkg::ST_FRAME;
                    n_sum  = '0;
                    n_len  = '0;
                end
            end
            stxd_pkg::ST_CSUM: begin
                o_res_valid = 1'b1;
                if (i_byte == r_sum) begin
                    n_good     = r_good + stxd_pkg::CntW'(1);
                    o_res.kind = stxd_pkg::KIND_GOOD;
                end else begin
                    n_err      = r_err + stxd_pkg::CntW'(1);
                    o_res.kind = stxd_pkg::KIND_BAD_SUM;
                end
                n_sum  = '0;
                n_len  = '0;
                n_mode = stxd_pkg::ST_IDLE;
            end
            stxd_pkg::ST_ESC: begin
                do_payload = 1'b1;
            end
            stxd_pkg::ST_FRAME: begin
                if (i_byte == stxd_pkg::Stx) begin
                    // A fresh STX aborts the frame and opens a new one at once.
                    o_res_valid = 1'b1;
                    o_res.kind  = stxd_pkg::KIND_ABORT;
                    n_err       = r_err + stxd_pkg::CntW'(1);
                    n_sum       = '0;
                    n_len       = '0;
                end else if (i_byte == stxd_pkg::Etx) begin
                    n_mode = stxd_pkg::ST_CSUM;
                end else if (i_byte == stxd_pkg::Dle) begin
                    n_mode = stxd_pkg::ST_ESC;
                end else begin
                    do_payload = 1'b1;
                end
            end
            default: begin
                n_mode = stxd_pkg::ST_IDLE;
            end
        endcase

        if (do_payload) begin
            o_res_valid  = 1'b1;
            o_res.length = len_inc;
            if (r_len >= limit) begin
                o_res.kind = stxd_pkg::KIND_LONG;
                n_sum      = '0;
                n_len      = '0;
                n_mode     = stxd_pkg::ST_IDLE;
            end else begin
                o_res.payload = i_byte;
                n_len         = len_inc;
                n_sum         = r_sum + i_byte;
                n_mode        = stxd_pkg::ST_FRAME;
            end
        end

        o_res.good_frames = n_good;
        o_res.err_frames  = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= stxd_pkg::ST_IDLE;
            r_sum     <= '0;
            r_len     <= '0;
            r_good    <= '0;
            r_err     <= '0;
            r_max_len <= stxd_pkg::MaxLenReset;
        end else begin
            if (i_adv) begin
                r_mode <= n_mode;
                r_sum  <= n_sum;
                r_len  <= n_len;
                r_good <= n_good;
                r_err  <= n_err;
            end
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    `STXD_ASSERT_IMP(a_idle_no_result, i_clk, i_rst_n, i_adv && (r_mode == stxd_pkg::ST_IDLE), !o_res_valid)
    `STXD_ASSERT_NXT(a_good_counts, i_clk, i_rst_n, i_adv && o_res_valid && (o_res.kind == stxd_pkg::KIND_GOOD), r_good == $past(r_good) + stxd_pkg::CntW'(1))
    `STXD_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, 32'(r_len) <= stxd_pkg::MaxFrame)

endmodule

// ----- rtl/stxd_out_stage.sv -----
// Output register of the frame decoder: holds one result until it is taken.
// Depends on stxd_pkg.
module stxd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  stxd_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output stxd_pkg::t_result o_res
);

    logic              r_valid;
    logic              n_valid;
    stxd_pkg::t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- tb/stxd_frame_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the STX/ETX/DLE frame decoder: follows the byte stream and
// the max_length writes, predicts every decoder result and compares it.
// Depends on stxd_pkg only.
module stxd_frame_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [stxd_pkg::ByteW-1:0] s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [stxd_pkg::DataW-1:0] m_axis_tdata,
    input  logic [stxd_pkg::KindW-1:0] m_axis_tuser,
    input  logic                       i_cfg_we,
    input  logic [stxd_pkg::LenW-1:0]  i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef enum logic [1:0] {
        RX_BETWEEN,
        RX_IN_FRAME,
        RX_AFTER_DLE,
        RX_WANT_SUM
    } t_rx_phase;

    typedef struct packed {
        stxd_pkg::t_kind                kind;
        logic [stxd_pkg::ByteW-1:0]     payload;
        logic [stxd_pkg::LenW-1:0]      length;
        logic [stxd_pkg::CntW-1:0]      good;
        logic [stxd_pkg::CntW-1:0]      bad;
    } t_frame_event;

    t_rx_phase                  rx_phase;
    logic [stxd_pkg::ByteW-1:0] csum;
    logic [stxd_pkg::LenW-1:0]  frame_len;
    logic [stxd_pkg::CntW-1:0]  good_cnt;
    logic [stxd_pkg::CntW-1:0]  bad_cnt;
    logic [stxd_pkg::LenW-1:0]  max_len;
    t_frame_event               pending_results[$];
    int                         fails = 0;

    assign o_fail_count = fails;

    function automatic void make_event(output t_frame_event ev, input stxd_pkg::t_kind k,
                                       input logic [stxd_pkg::ByteW-1:0] b,
                                       input logic [stxd_pkg::LenW-1:0] len);
        ev.kind    = k;
        ev.payload = b;
        ev.length  = len;
        ev.good    = good_cnt;
        ev.bad     = bad_cnt;
    endfunction

    // A payload byte either extends the frame or, past the clamped limit, drops it.
    function automatic void take_byte(input logic [stxd_pkg::ByteW-1:0] c,
                                      output t_frame_event ev);
        logic [stxd_pkg::LenW-1:0] cap;
        logic [stxd_pkg::LenW:0]   next_len;
        cap = (max_len > stxd_pkg::LenW'(stxd_pkg::MaxFrame)) ?
              stxd_pkg::LenW'(stxd_pkg::MaxFrame) : max_len;
        if (frame_len >= cap) begin
            next_len = {1'b0, frame_len} + 1'b1;
            if (next_len > {1'b0, {stxd_pkg::LenW{1'b1}}}) begin
                next_len = {1'b0, {stxd_pkg::LenW{1'b1}}};
            end
            make_event(ev, stxd_pkg::KIND_LONG, '0, next_len[stxd_pkg::LenW-1:0]);
            csum      = '0;
            frame_len = '0;
            rx_phase  = RX_BETWEEN;
        end else begin
            frame_len = frame_len + 1'b1;
            csum      = csum + c;
            rx_phase  = RX_IN_FRAME;
            make_event(ev, stxd_pkg::KIND_PAYLOAD, c, frame_len);
        end
    endfunction

    // Returns 1 when the byte gives a result.
    function automatic bit decode_byte(input logic [stxd_pkg::ByteW-1:0] c,
                                       output t_frame_event ev);
        ev = '0;
        case (rx_phase)
            RX_BETWEEN: begin
                if (c == stxd_pkg::Stx) begin
                    rx_phase  = RX_IN_FRAME;
                    csum      = '0;
                    frame_len = '0;
                end
                return 1'b0;
            end
            RX_WANT_SUM: begin
                if (c == csum) begin
                    good_cnt = good_cnt + 1'b1;
                    make_event(ev, stxd_pkg::KIND_GOOD, '0, frame_len);
                end else begin
                    bad_cnt = bad_cnt + 1'b1;
                    make_event(ev, stxd_pkg::KIND_BAD_SUM, '0, frame_len);
                end
                csum      = '0;
                frame_len = '0;
                rx_phase  = RX_BETWEEN;
                return 1'b1;
            end
            RX_AFTER_DLE: begin
                take_byte(c, ev);
                return 1'b1;
            end
            default: begin
                if (c == stxd_pkg::Stx) begin
                    bad_cnt = bad_cnt + 1'b1;
                    make_event(ev, stxd_pkg::KIND_ABORT, '0, frame_len);
                    csum      = '0;
                    frame_len = '0;
                    rx_phase  = RX_IN_FRAME;
                    return 1'b1;
                end
                if (c == stxd_pkg::Etx) begin
                    rx_phase = RX_WANT_SUM;
                    return 1'b0;
                end
                if (c == stxd_pkg::Dle) begin
                    rx_phase = RX_AFTER_DLE;
                    return 1'b0;
                end
                take_byte(c, ev);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [stxd_pkg::CntW-1:0] want,
                               input logic [stxd_pkg::CntW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_event want;
        t_frame_event ev;
        if (!i_rst_n) begin
            rx_phase  = RX_BETWEEN;
            csum      = '0;
            frame_len = '0;
            good_cnt  = '0;
            bad_cnt   = '0;
            max_len   = stxd_pkg::MaxLenReset;
            pending_results.delete();
        end else begin
            // Results first, so a result never meets the byte taken at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result of kind %0d arrived with none outstanding", m_axis_tuser);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("payload_byte", want.payload, m_axis_tdata[7:0]);
                    check_field("frame_length", want.length, m_axis_tdata[20:8]);
                    check_field("good_frames", want.good, m_axis_tdata[52:21]);
                    check_field("error_frames", want.bad, m_axis_tdata[84:53]);
                end
            end
            if (i_cfg_we) begin
                max_len = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_byte(s_axis_tdata, ev)) begin
                    pending_results.push_back(ev);
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

// ----- tb/tb_stx_etx_dle_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the STX/ETX/DLE frame decoder: clock, reset, byte stimulus,
// back-pressure on the result channel and the final verdict.
// Depends on stxd_pkg, stxd_frame_checker and the decoder RTL.
module tb_stx_etx_dle_frame_decoder_top;

    // The cap on the run is far above the slowest correct run, even with the
    // longest gaps and stalls.
    localparam int CycleLimit  = 1_000_000;
    // A result is offered once its byte has passed the input and output registers;
    // this wait leaves ample margin for bytes that give no result.
    localparam int DrainCycles = 8;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [stxd_pkg::ByteW-1:0] s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [stxd_pkg::DataW-1:0] m_axis_tdata;
    logic [stxd_pkg::KindW-1:0] m_axis_tuser;
    logic                       i_cfg_we      = 1'b0;
    logic [stxd_pkg::LenW-1:0]  i_cfg_wdata   = '0;

    int fail_count;
    int outstanding;
    int cycles    = 0;
    int sent      = 0;
    // Percentages of idling on each side; both are changed from phase to phase.
    int gap_pct   = 20;
    int stall_pct = 20;
    // The effective length limit of the current phase, used to size frames.
    int cur_cap   = stxd_pkg::MaxFrame;
    // Set for the last phase, in which neither side idles.
    bit quiet     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    stx_etx_dle_frame_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    stxd_frame_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (outstanding)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("tb_stx_etx_dle_frame_decoder_top: done, errors");
            $finish;
        end
    end

    // Back-pressure on the result channel: bursts of stalled cycles at random,
    // with long stretches of readiness between them when stall_pct is low.
    // Each step sees at most one assignment to tready.
    initial begin : result_backpressure
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Offers one byte and returns at the edge of its transfer. tvalid is left
    // high, so that back-to-back bytes follow without a bubble; the next call
    // either replaces the data in the same step or opens an idle gap.
    task automatic send_byte(input logic [stxd_pkg::ByteW-1:0] b);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    // Waits until every predicted result has been taken, then lets the input
    // register drain of bytes that give no result. The first edge makes sure
    // the checker has already counted the last transfer.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // max_length is only ever written with the decoder idle.
    task automatic write_max_len(input logic [stxd_pkg::LenW-1:0] v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_cap = (v > stxd_pkg::MaxFrame) ? stxd_pkg::MaxFrame : int'(v);
    endtask

    // A well-formed frame of n payload bytes. Control characters in the
    // payload are always escaped, and now and then an ordinary byte is too.
    // With sum_ok clear the checksum is corrupted; with close clear the frame
    // is left open, so that whatever follows is taken into it or aborts it.
    task automatic send_frame(input int n, input bit sum_ok, input bit close);
        logic [stxd_pkg::ByteW-1:0] b;
        logic [stxd_pkg::ByteW-1:0] sum;
        sum = '0;
        send_byte(stxd_pkg::Stx);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0:       b = stxd_pkg::Stx;
                    1:       b = stxd_pkg::Etx;
                    default: b = stxd_pkg::Dle;
                endcase
            end else begin
                b = stxd_pkg::ByteW'($urandom_range(0, 255));
            end
            sum = sum + b;
            if (b == stxd_pkg::Stx || b == stxd_pkg::Etx || b == stxd_pkg::Dle ||
                $urandom_range(0, 15) == 0) begin
                send_byte(stxd_pkg::Dle);
            end
            send_byte(b);
        end
        if (close) begin
            send_byte(stxd_pkg::Etx);
            send_byte(sum_ok ? sum : sum ^ stxd_pkg::ByteW'($urandom_range(1, 255)));
        end
    endtask

    // Mostly well-formed frames with random content; the rest are bad
    // checksums, frames cut short by the next STX, frames of raw unescaped
    // bytes, and line noise between frames. Near small limits the lengths
    // straddle the limit so that frames are dropped as too long.
    task automatic send_random_frame();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (cur_cap < 12) begin
            n = $urandom_range(0, cur_cap + 2);
        end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(0, 40);
        end else begin
            n = $urandom_range(0, 12);
        end
        if (pick < 60) begin
            send_frame(n, 1'b1, 1'b1);
        end else if (pick < 72) begin
            send_frame(n, 1'b0, 1'b1);
        end else if (pick < 80) begin
            send_frame(n, 1'b1, 1'b0);
        end else if (pick < 90) begin
            send_byte(stxd_pkg::Stx);
            repeat (n) send_byte(stxd_pkg::ByteW'($urandom_range(0, 255)));
            send_byte(stxd_pkg::Etx);
            send_byte(stxd_pkg::ByteW'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_byte(stxd_pkg::ByteW'($urandom_range(0, 255)));
            end
        end
    endtask

    // One setting of max_length followed by random frames until the phase has
    // moved its share of bytes. Idling rates are drawn afresh for each phase.
    task automatic run_phase(input logic [stxd_pkg::LenW-1:0] max_len, input int budget);
        int first;
        write_max_len(max_len);
        gap_pct   = $urandom_range(0, 40);
        stall_pct = $urandom_range(0, 40);
        first     = sent;
        while (sent - first < budget) send_random_frame();
    endtask

    initial begin : stimulus
        logic [stxd_pkg::ByteW-1:0] opening [26];

        // Two bytes of noise before any frame, then a frame whose payload
        // holds escaped STX, ETX and DLE and the byte extremes, an empty frame
        // with a zero checksum, a bad checksum that happens to equal STX, and
        // a frame aborted by a fresh STX that then completes as a good one.
        opening = '{8'hFF, stxd_pkg::Etx,
                    stxd_pkg::Stx, 8'hFF, stxd_pkg::Dle, stxd_pkg::Stx,
                    stxd_pkg::Dle, stxd_pkg::Etx, stxd_pkg::Dle, stxd_pkg::Dle,
                    8'h00, stxd_pkg::Etx, 8'h14,
                    stxd_pkg::Stx, stxd_pkg::Etx, 8'h00,
                    stxd_pkg::Stx, 8'h41, stxd_pkg::Etx, stxd_pkg::Stx,
                    stxd_pkg::Stx, 8'h55, stxd_pkg::Stx, 8'h01, stxd_pkg::Etx, 8'h01};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[k]) send_byte(opening[k]);

        run_phase(stxd_pkg::MaxLenReset, 160);
        run_phase(stxd_pkg::LenW'(1), 140);
        run_phase(stxd_pkg::LenW'(0), 100);
        // A limit above the largest frame is clamped to it.
        run_phase({stxd_pkg::LenW{1'b1}}, 140);
        run_phase(stxd_pkg::LenW'(3), 140);
        run_phase(stxd_pkg::LenW'(16), 160);
        run_phase(stxd_pkg::LenW'($urandom_range(1, 64)), 160);

        // The closing phase runs at full rate on both sides.
        settle();
        quiet <= 1'b1;
        run_phase(stxd_pkg::MaxLenReset, 150);

        settle();
        if (fail_count == 0) begin
            $display("tb_stx_etx_dle_frame_decoder_top: done, clean");
        end else begin
            $display("tb_stx_etx_dle_frame_decoder_top: done, errors");
        end
        $finish;
    end

endmodule
